/* design/aol_pkg.sv */
`timescale 1ns / 1ps

package aol_pkg;

    localparam int ADDR_W      = 20;
    localparam int LOOP_DEPTH  = 1 << ADDR_W;
    localparam int LEN_W       = ADDR_W + 1;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_W       = SAMPLE_BITS + 1;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = SUM_W + GAIN_W + 1;
    localparam int WORD_W      = 2 * SAMPLE_BITS;
    localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * SUM_W + 3 + LEN_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_DATA_W  = LEN_W;

    localparam logic [GAIN_W-1:0] GAIN_OUT   = GAIN_W'(26870);
    localparam logic [GAIN_W-1:0] DECAY_LOW  = GAIN_W'(26214);
    localparam logic [GAIN_W-1:0] DECAY_HIGH = GAIN_W'(32768);
    localparam logic [GAIN_W-1:0] DECAY_RST  = GAIN_W'(31130);
    localparam logic [LEN_W-1:0]  MIN_LEN_RST = LEN_W'(2400);
    localparam logic signed [PROD_W-1:0] ROUND_Q15 = PROD_W'(16384);

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TOGGLE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_STOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_DECAY   = 2'd0,
        CFG_STEREO  = 2'd1,
        CFG_MIN_LEN = 2'd2
    } cfg_index_t;

    function automatic logic signed [SUM_W-1:0] mul_q15(
        input logic signed [SUM_W-1:0] a,
        input logic [GAIN_W-1:0] g
    );
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'($signed({1'b0, g}));
        p = p + ROUND_Q15;
        return p[SUM_W+14:15];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
        logic [SAMPLE_BITS-1:0] r;
        if (v[SUM_W-1] != v[SUM_W-2]) begin
            r = {v[SUM_W-1], {(SAMPLE_BITS-1){~v[SUM_W-1]}}};
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* design/aol_ram.sv */
`timescale 1ns / 1ps

module aol_ram (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [aol_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [aol_pkg::WORD_W-1:0]     wr_data,
    input  logic                           rd_en,
    input  logic [aol_pkg::ADDR_W-1:0]     rd_addr,
    output logic [aol_pkg::WORD_W-1:0]     rd_data
);

    logic [aol_pkg::WORD_W-1:0] mem [aol_pkg::LOOP_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/audio_overdub_looper_top.sv */
`timescale 1ns / 1ps
// Flow: a command or a first-take sample passes ST_DONE, then its result word is registered;
// a playback or overdub sample passes ST_READ and ST_MIX (the memory read issues at acceptance,
// then feedback multiply, then output gain). Each waits in its last state until the output word is taken.
// A new item is taken only in ST_IDLE, once the last one is finished; the two multiplies of the
// read-modify-write are chained. The output register holds one finished word.
// Reset clears control state and loads the register defaults; the loop memory is not cleared.
module audio_overdub_looper_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // left_in [15:0], right_in [31:16]
    input  logic [aol_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind [1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_out [16:0], right_out [33:17], recording_on [34], capturing [35],
    // has_loop [36], loop_samples [57:37], zero fill above
    output logic [aol_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [aol_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SB = aol_pkg::SAMPLE_BITS;
    localparam int SW = aol_pkg::SUM_W;
    localparam int AW = aol_pkg::ADDR_W;
    localparam int LW = aol_pkg::LEN_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_MIX  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [aol_pkg::GAIN_W-1:0] decay_reg;
    logic                       stereo_reg;
    logic [LW-1:0]              min_len_reg;

    logic [LW-1:0] loop_len_reg, loop_len_next;
    logic [LW-1:0] cap_pos_reg, cap_pos_next;
    logic [AW-1:0] play_pos_reg, play_pos_next;
    logic          rec_reg, rec_next;
    logic          first_reg, first_next;

    aol_pkg::kind_t         kind_reg, kind_next;
    logic signed [SB-1:0]   left_reg, left_next;
    logic signed [SB-1:0]   right_reg, right_next;
    logic signed [SW-1:0]   sum_l_reg, sum_l_next;
    logic signed [SW-1:0]   sum_r_reg, sum_r_next;

    logic                              out_valid_reg, out_valid_next;
    logic [aol_pkg::OUT_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [aol_pkg::WORD_W-1:0]    mem_wdata, mem_rdata;

    logic                      slot_free, do_end, load_out;
    logic [aol_pkg::GAIN_W-1:0] decay_use;
    logic signed [SW-1:0]      st_l, st_r, out_l, out_r;
    logic [LW-1:0]             play_inc;

    aol_ram u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        if (decay_reg < aol_pkg::DECAY_LOW) begin
            decay_use = aol_pkg::DECAY_LOW;
        end else if (decay_reg > aol_pkg::DECAY_HIGH) begin
            decay_use = aol_pkg::DECAY_HIGH;
        end else begin
            decay_use = decay_reg;
        end
    end

    assign st_l     = SW'($signed(mem_rdata[SB-1:0]));
    assign st_r     = SW'($signed(mem_rdata[2*SB-1:SB]));
    assign out_l    = aol_pkg::mul_q15(sum_l_reg, aol_pkg::GAIN_OUT);
    assign out_r    = aol_pkg::mul_q15(sum_r_reg, aol_pkg::GAIN_OUT);
    assign play_inc = {1'b0, play_pos_reg} + LW'(1);

    always_comb begin
        state_next    = state_reg;
        loop_len_next = loop_len_reg;
        cap_pos_next  = cap_pos_reg;
        play_pos_next = play_pos_reg;
        rec_next      = rec_reg;
        first_next    = first_reg;
        kind_next     = kind_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        sum_l_next    = sum_l_reg;
        sum_r_next    = sum_r_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = play_pos_reg;
        mem_wdata     = {aol_pkg::sat_sample(sum_r_reg), aol_pkg::sat_sample(sum_l_reg)};
        mem_raddr     = play_pos_reg;
        do_end        = 1'b0;
        load_out      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = aol_pkg::kind_t'(s_tuser);
                    left_next  = $signed(s_tdata[SB-1:0]);
                    right_next = stereo_reg ? $signed(s_tdata[2*SB-1:SB])
                                            : $signed(s_tdata[SB-1:0]);
                    if (aol_pkg::kind_t'(s_tuser) == aol_pkg::KIND_SAMPLE &&
                        !(rec_reg && first_reg) && loop_len_reg != '0) begin
                        mem_re     = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                if (rec_reg) begin
                    sum_l_next = aol_pkg::mul_q15(st_l, decay_use) + SW'(left_reg);
                    sum_r_next = aol_pkg::mul_q15(st_r, decay_use) + SW'(right_reg);
                end else begin
                    sum_l_next = st_l;
                    sum_r_next = st_r;
                end
                state_next = ST_MIX;
            end
            ST_MIX: begin
                if (slot_free) begin
                    load_out      = 1'b1;
                    mem_we        = rec_reg;
                    play_pos_next = (play_inc == loop_len_reg) ? '0 : play_inc[AW-1:0];
                    state_next    = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    case (kind_reg)
                        aol_pkg::KIND_TOGGLE: begin
                            if (rec_reg) begin
                                do_end = 1'b1;
                            end else begin
                                rec_next   = 1'b1;
                                first_next = (loop_len_reg == '0);
                                if (loop_len_reg == '0) begin
                                    cap_pos_next  = '0;
                                    play_pos_next = '0;
                                end
                            end
                        end
                        aol_pkg::KIND_CLEAR: begin
                            rec_next      = 1'b0;
                            first_next    = 1'b0;
                            cap_pos_next  = '0;
                            play_pos_next = '0;
                            loop_len_next = '0;
                        end
                        aol_pkg::KIND_STOP: begin
                            do_end = 1'b1;
                        end
                        default: begin
                            if (rec_reg && first_reg) begin
                                mem_we       = 1'b1;
                                mem_waddr    = cap_pos_reg[AW-1:0];
                                mem_wdata    = {right_reg, left_reg};
                                cap_pos_next = cap_pos_reg + LW'(1);
                                if (cap_pos_next == LW'(aol_pkg::LOOP_DEPTH)) begin
                                    do_end = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_end) begin
            if (rec_reg && first_reg) begin
                loop_len_next = (cap_pos_next <= min_len_reg) ? '0 : cap_pos_next;
                play_pos_next = '0;
            end
            rec_next   = 1'b0;
            first_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            if (state_reg == ST_MIX) begin
                out_data_next[SW-1:0]    = out_l;
                out_data_next[2*SW-1:SW] = out_r;
            end
            out_data_next[2*SW]              = rec_next;
            out_data_next[2*SW+1]            = rec_next && first_next;
            out_data_next[2*SW+2]            = (loop_len_next != '0);
            out_data_next[2*SW+3+LW-1:2*SW+3] = loop_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            loop_len_reg  <= '0;
            cap_pos_reg   <= '0;
            play_pos_reg  <= '0;
            rec_reg       <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            decay_reg     <= aol_pkg::DECAY_RST;
            stereo_reg    <= 1'b0;
            min_len_reg   <= aol_pkg::MIN_LEN_RST;
        end else begin
            state_reg     <= state_next;
            loop_len_reg  <= loop_len_next;
            cap_pos_reg   <= cap_pos_next;
            play_pos_reg  <= play_pos_next;
            rec_reg       <= rec_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    aol_pkg::CFG_DECAY: begin
                        decay_reg <= cfg_data[aol_pkg::GAIN_W-1:0];
                    end
                    aol_pkg::CFG_STEREO: begin
                        stereo_reg <= cfg_data[0];
                    end
                    aol_pkg::CFG_MIN_LEN: begin
                        min_len_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        sum_l_reg    <= sum_l_next;
        sum_r_reg    <= sum_r_next;
        out_data_reg <= out_data_next;
    end

    a_play_in_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        loop_len_reg != '0 |-> {1'b0, play_pos_reg} < loop_len_reg)
        else $error("play position outside the loop");

    a_capture_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_reg && first_reg) |-> cap_pos_reg < LW'(aol_pkg::LOOP_DEPTH))
        else $error("capture position past the end of the store");

    a_silent_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2*SW+1]) |-> (m_tdata[2*SW-1:0] == '0 && m_tdata[2*SW]))
        else $error("first take word carries audio or lacks the recording flag");

    a_has_loop_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*SW+2] == (m_tdata[2*SW+3+LW-1:2*SW+3] != '0)))
        else $error("loop flag disagrees with loop length");

    a_read_then_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |=> state_reg == ST_READ)
        else $error("memory read not followed by its data stage");

endmodule
